// ===== hw/rtl/igc_pkg.sv =====
// ----------------------------------------------------------------------------
// igc_pkg
// Shared types and constants for the graph coloring block: transaction
// payloads, queue command format and sequencer state codes.
// ----------------------------------------------------------------------------
package igc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int KIND_W           = 2;
  localparam int ROW_IDX_W        = 6;
  localparam int ROW_BITS_W       = 64;
  localparam int VERTEX_W         = 6;
  localparam int COLOR_W          = 6;
  localparam int VCOUNT_W         = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd64;
  localparam int QUEUE_DEPTH      = 2;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_ADJ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_GRP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN      = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD_ADJ = 2'd0,
    OP_LOAD_GRP = 2'd1,
    OP_RUN      = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [ROW_IDX_W-1:0]  row;
    logic [ROW_BITS_W-1:0] bits;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GRP  = 5'b00010,
    ST_P2   = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

endpackage

// ===== hw/rtl/igc_fifo.sv =====
// ----------------------------------------------------------------------------
// igc_fifo
// Small register queue with full/empty flags; parts the front from the
// back and the back from the result consumer.
// ----------------------------------------------------------------------------
module igc_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import igc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/igc_front.sv =====
// ----------------------------------------------------------------------------
// igc_front
// Input side: takes transactions, drops unused kinds and out-of-range row
// loads, and turns the rest into commands for the back end queue.
// ----------------------------------------------------------------------------
module igc_front #(
  parameter int MAX_VERTICES = igc_pkg::MAX_VERTICES_DEF
) (
  input  logic              in_push,
  output logic              in_full,
  input  igc_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output igc_pkg::cmd_t     q_item
);
  import igc_pkg::*;

  logic row_ok;
  logic keep;

  assign row_ok  = ({1'b0, in_item.row_index} < (ROW_IDX_W+1)'(MAX_VERTICES));
  assign in_full = q_full;

  always_comb begin
    keep        = 1'b0;
    q_item.op   = OP_RUN;
    q_item.row  = in_item.row_index;
    q_item.bits = in_item.row_bits;
    unique case (in_item.kind)
      KIND_LOAD_ADJ: begin
        keep      = row_ok;
        q_item.op = OP_LOAD_ADJ;
      end
      KIND_LOAD_GRP: begin
        keep      = row_ok;
        q_item.op = OP_LOAD_GRP;
      end
      KIND_RUN: begin
        keep      = 1'b1;
        q_item.op = OP_RUN;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Dropped transactions are still accepted, they just never reach the queue
  assign q_push = in_push && !q_full && keep;

endmodule

// ===== hw/rtl/igc_back.sv =====
// ----------------------------------------------------------------------------
// igc_back
// Coloring engine: row memories, color class memory, per-vertex color
// lanes and the sequencer for group pass, first-fit pass and readout.
// ----------------------------------------------------------------------------
module igc_back #(
  parameter int MAX_VERTICES = igc_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [igc_pkg::VCOUNT_W-1:0] cfg_wr_data,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  input  igc_pkg::cmd_t                cmd_item,
  input  logic                         res_full,
  output logic                         res_push,
  output igc_pkg::out_item_t           res_item
);
  import igc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  back_state_t             state_r, state_nxt;
  logic [VCOUNT_W-1:0]     vcount_r;
  logic [VW-1:0]           last_r;
  logic [MAX_VERTICES-1:0] vmask_r;
  logic [VW-1:0]           idx_r, idx_nxt;
  logic [VW-1:0]           c_r, c_nxt;
  logic [CW-1:0]           ncol_r, ncol_nxt;
  logic [MAX_VERTICES-1:0] colored_r, colored_nxt;
  logic [MAX_VERTICES-1:0] nbrs_r;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] grp_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cls_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_r;
  logic [MAX_VERTICES-1:0] grp_rd_r;
  logic [MAX_VERTICES-1:0] cls_rd_r;

  logic [VW-1:0]           lane_r [MAX_VERTICES];

  logic [CW-1:0]           n_run;
  logic                    is_last;
  logic [MAX_VERTICES-1:0] members;
  logic                    grp_take;
  logic                    fresh;
  logic                    fit;
  logic [MAX_VERTICES-1:0] self_bit;
  logic                    start_run;
  logic                    load_adj;
  logic                    load_grp;
  logic                    grp_wr;
  logic                    scan_wr;

  assign n_run = (vcount_r > VCOUNT_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_r);
  assign is_last  = (idx_r == last_r);
  assign members  = grp_rd_r & vmask_r;
  assign grp_take = (members != '0) && ((members & colored_r) == '0);
  assign fresh    = (CW'(c_r) == ncol_r);
  assign fit      = fresh || ((cls_rd_r & nbrs_r) == '0);
  assign self_bit = MAX_VERTICES'(1) << idx_r;

  assign cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
  assign load_adj  = cmd_pop && (cmd_item.op == OP_LOAD_ADJ);
  assign load_grp  = cmd_pop && (cmd_item.op == OP_LOAD_GRP);
  assign start_run = cmd_pop && (cmd_item.op == OP_RUN) && (n_run != '0);
  assign grp_wr    = (state_r == ST_GRP) && grp_take;
  assign scan_wr   = (state_r == ST_SCAN) && fit;

  assign res_push        = (state_r == ST_OUT) && !res_full;
  assign res_item.vertex = VERTEX_W'(idx_r);
  assign res_item.color  = COLOR_W'(lane_r[0]);
  assign res_item.last   = is_last;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    c_nxt       = c_r;
    ncol_nxt    = ncol_r;
    colored_nxt = colored_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (start_run) begin
          colored_nxt = '0;
          ncol_nxt    = '0;
          state_nxt   = ST_GRP;
        end
      end
      ST_GRP: begin
        if (grp_take) begin
          colored_nxt = colored_r | members;
          ncol_nxt    = ncol_r + 1'b1;
        end
        if (is_last) begin
          idx_nxt   = '0;
          state_nxt = ST_P2;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_P2: begin
        c_nxt = '0;
        if (colored_r[idx_r]) begin
          if (is_last) begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fit) begin
          colored_nxt = colored_r | self_bit;
          if (fresh) begin
            ncol_nxt = ncol_r + 1'b1;
          end
          c_nxt = '0;
          if (is_last) begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_P2;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (res_push) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= VCOUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    c_r       <= c_nxt;
    ncol_r    <= ncol_nxt;
    colored_r <= colored_nxt;
    if (start_run) begin
      last_r <= VW'(n_run - 1'b1);
      for (int k = 0; k < MAX_VERTICES; k++) begin
        vmask_r[k] <= (CW'(k) < n_run);
      end
    end
    // Hold the neighbour row for the whole color search
    if (state_r == ST_P2) begin
      nbrs_r <= adj_rd_r;
    end
  end

  // Row memories: written by loads, read one row a cycle during a run
  always_ff @(posedge clk) begin
    if (load_adj) begin
      adj_mem[cmd_item.row[VW-1:0]] <= cmd_item.bits[MAX_VERTICES-1:0];
    end
    adj_rd_r <= adj_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (load_grp) begin
      grp_mem[cmd_item.row[VW-1:0]] <= cmd_item.bits[MAX_VERTICES-1:0];
    end
    grp_rd_r <= grp_mem[idx_nxt];
  end

  // Color class memory: vertex set per color; entries at or above ncol_r are stale
  always_ff @(posedge clk) begin
    if (grp_wr) begin
      cls_mem[ncol_r[VW-1:0]] <= members;
    end else if (scan_wr) begin
      cls_mem[c_r] <= fresh ? self_bit : (cls_rd_r | self_bit);
    end
    cls_rd_r <= cls_mem[c_nxt];
  end

  // Color lanes: one per vertex, shifted down toward lane 0 during readout
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_lane
    logic [VW-1:0] shift_in;
    if (k < MAX_VERTICES - 1) begin : g_mid
      assign shift_in = lane_r[k+1];
    end else begin : g_top
      assign shift_in = lane_r[k];
    end
    always_ff @(posedge clk) begin
      if (grp_wr && members[k]) begin
        lane_r[k] <= ncol_r[VW-1:0];
      end else if (scan_wr && (idx_r == VW'(k))) begin
        lane_r[k] <= c_r;
      end else if (res_push) begin
        lane_r[k] <= shift_in;
      end
    end
  end

endmodule

// ===== hw/rtl/independent_set_then_greedy_coloring_top.sv =====
// ----------------------------------------------------------------------------
// independent_set_then_greedy_coloring_top
// Group-first then first-fit graph coloring with queue style ports.
// ----------------------------------------------------------------------------
// Usage: push transactions on in_item while in_full is low. A load writes
// one adjacency or group row; a run colors the first vertex_count vertices
// (at most MAX_VERTICES) and queues one result per vertex (vertex order,
// last set on the final one). Results wait on out_item while out_empty is
// low; pop takes one. cfg_wr_en/cfg_wr_data set vertex_count; write it
// only while idle. Loads retire one per cycle, while the engine is idle,
// after a queue stage. A run of n vertices does a group pass over all n
// vertices, then for each uncolored vertex a scan of the color classes,
// one class memory read a cycle, until one fits (already colored vertices
// are skipped), and then a readout of the n results in vertex order.
// Only one run is in progress at a time; further transactions wait in the
// command queue. A stalled receiver holds the readout, and the two-entry
// queues fill and raise in_full. Reset empties both queues, sets
// vertex_count to 64 and returns the engine to idle; rows hold no value
// until loaded.
// ----------------------------------------------------------------------------
module independent_set_then_greedy_coloring_top #(
  parameter int MAX_VERTICES = igc_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  igc_pkg::in_item_t            in_item,
  output logic                         out_empty,
  input  logic                         out_pop,
  output igc_pkg::out_item_t           out_item,
  input  logic                         cfg_wr_en,
  input  logic [igc_pkg::VCOUNT_W-1:0] cfg_wr_data
);
  import igc_pkg::*;

  cmd_t      q_wr_item;
  cmd_t      q_rd_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  out_item_t res_item;
  logic      res_push;
  logic      res_full;

  igc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  igc_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_item),
    .empty   (q_empty)
  );

  igc_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_empty   (q_empty),
    .cmd_pop     (q_pop),
    .cmd_item    (q_rd_item),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  igc_fifo #(
    .WIDTH($bits(out_item_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule
